// ===== hdl/id3v2_tag_frame_parser_top_defines.svh =====
// Assertion macros for the ID3v2 tag frame parser.
`ifndef ID3V2_TAG_FRAME_PARSER_TOP_DEFINES_SVH
`define ID3V2_TAG_FRAME_PARSER_TOP_DEFINES_SVH

// Same-cycle implication, checked outside of reset.
`define IDTP_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside of reset.
`define IDTP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hdl/idtp_pkg.sv =====
// Package with types, codes and helper functions of the ID3v2 tag frame parser.
`default_nettype none
package idtp_pkg;

  localparam int SIZE_BITS = 28;
  localparam int MAX_RES   = 3;

  localparam logic [1:0] EV_TAG    = 2'd0;
  localparam logic [1:0] EV_TEXT   = 2'd1;
  localparam logic [1:0] EV_NUMBER = 2'd2;
  localparam logic [1:0] EV_FINISH = 2'd3;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_NOT_ID3   = 3'd1;
  localparam logic [2:0] ST_BAD_TAG   = 3'd2;
  localparam logic [2:0] ST_BAD_FRAME = 3'd3;
  localparam logic [2:0] ST_TRUNC     = 3'd4;

  localparam logic [4:0] CAT_LAST_TEXT = 5'd12;
  localparam logic [4:0] CAT_ALBUM     = 5'd8;
  localparam logic [4:0] CAT_TRACK     = 5'd13;
  localparam logic [4:0] CAT_DISC      = 5'd15;
  localparam logic [4:0] CAT_NONE      = 5'd31;

  localparam logic [27:0] MAX_TAG_RESET = 28'd300000;

  typedef enum logic [5:0] {
    PH_HEADER    = 6'b000001,
    PH_FRAME_HDR = 6'b000010,
    PH_ENC       = 6'b000100,
    PH_VALUE     = 6'b001000,
    PH_PADDING   = 6'b010000,
    PH_DONE      = 6'b100000
  } phase_t;

  typedef struct packed {
    logic [1:0]  ev;
    logic [4:0]  cat;
    logic [7:0]  tb;
    logic        bv;
    logic        last;
    logic [31:0] num;
    logic [2:0]  st;
    logic        alb;
  } res_t;

  function automatic res_t mk_res(input logic [1:0] ev, input logic [4:0] cat,
                                  input logic [7:0] tb, input logic bv, input logic last,
                                  input logic [31:0] num, input logic [2:0] st,
                                  input logic alb);
    res_t r;
    r.ev = ev; r.cat = cat; r.tb = tb; r.bv = bv; r.last = last;
    r.num = num; r.st = st; r.alb = alb;
    return r;
  endfunction

  function automatic logic [31:0] size_push(input logic [31:0] acc, input logic [7:0] b,
                                            input logic sync);
    logic [31:0] r;
    if (sync) begin
      r = {acc[31] | b[7], acc[23:0], b[6:0]};
    end else begin
      r = {acc[23:0], b};
    end
    return r;
  endfunction

  function automatic logic [4:0] classify(input logic [31:0] id);
    logic [4:0] c;
    case (id)
      "TIT1": c = 5'd0;
      "TIT2": c = 5'd1;
      "TIT3": c = 5'd2;
      "TLAN": c = 5'd3;
      "TCOP": c = 5'd4;
      "TDRL", "TDAT", "TYER", "TDRC": c = 5'd5;
      "TPE1", "TPE2", "TPE3", "TPE4": c = 5'd6;
      "TPUB", "TENC": c = 5'd7;
      "TALB", "TOAL": c = CAT_ALBUM;
      "TCON": c = 5'd9;
      "TLEN": c = 5'd10;
      "TEXT": c = 5'd11;
      "TCOM": c = 5'd12;
      "TRCK": c = CAT_TRACK;
      "TPOS": c = CAT_DISC;
      default: c = CAT_NONE;
    endcase
    return c;
  endfunction

  function automatic logic [31:0] acc_value(input logic [32:0] a);
    logic [31:0] r;
    if (a[32]) begin
      r = 32'd0 - a[31:0];
    end else if (a[31]) begin
      r = 32'h7FFF_FFFF;
    end else begin
      r = a[31:0];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== hdl/idtp_step.sv =====
// Per-byte parser state and the results that one accepted byte produces.
`default_nettype none
module idtp_step import idtp_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        accept,
  input  wire logic [7:0]  data_byte,
  input  wire logic        end_of_stream,
  input  wire logic [27:0] max_tag_size,
  output res_t             res_next [MAX_RES],
  output logic [1:0]       nres_next,
  output phase_t           phase
);

  logic [3:0]  header_position;
  logic        syncsafe_mode;
  logic [31:0] size_shift;
  logic [27:0] tag_remaining;
  logic [31:0] frame_id;
  logic [27:0] value_remaining;
  logic [4:0]  frame_category;
  logic [32:0] acc [2];
  logic [2:0]  number_parse_state;
  logic        album_seen;

  phase_t      phase_next;
  logic [3:0]  header_position_next;
  logic        syncsafe_mode_next;
  logic [31:0] size_shift_next;
  logic [27:0] tag_remaining_next;
  logic [31:0] frame_id_next;
  logic [27:0] value_remaining_next;
  logic [4:0]  frame_category_next;
  logic [32:0] acc_next [2];
  logic [2:0]  number_parse_state_next;
  logic        album_seen_next;

  logic        ok, do_end, end_empty, slot, digit, space;
  logic [1:0]  sub;
  logic [3:0]  pos;
  logic [34:0] mag;
  logic [31:0] first, cnt;
  logic [7:0]  b;

  always_comb begin
    b = data_byte;
    phase_next = phase;
    header_position_next = header_position;
    syncsafe_mode_next = syncsafe_mode;
    size_shift_next = size_shift;
    tag_remaining_next = tag_remaining;
    frame_id_next = frame_id;
    value_remaining_next = value_remaining;
    frame_category_next = frame_category;
    acc_next[0] = acc[0];
    acc_next[1] = acc[1];
    number_parse_state_next = number_parse_state;
    album_seen_next = album_seen;
    for (int i = 0; i < MAX_RES; i++) begin
      res_next[i] = '0;
    end
    nres_next = 2'd0;
    ok = 1'b1;
    do_end = 1'b0;
    end_empty = 1'b0;
    pos = header_position;
    slot = number_parse_state[2];
    sub = number_parse_state[1:0];
    digit = (b >= 8'h30) && (b <= 8'h39);
    space = (b == 8'h20) || ((b >= 8'h09) && (b <= 8'h0D));
    mag = '0;
    first = '0;
    cnt = '0;

    case (phase)
      PH_HEADER: begin
        case (pos)
          4'd0: ok = (b == 8'h49);
          4'd1: ok = (b == 8'h44);
          4'd2: ok = (b == 8'h33);
          4'd3: begin
            ok = (b <= 8'd4);
            syncsafe_mode_next = (b == 8'd4);
            size_shift_next = '0;
          end
          4'd5: ok = (b == 8'd0);
          default: begin
            if (pos >= 4'd6) begin
              size_shift_next = size_push(size_shift, b, syncsafe_mode);
            end
          end
        endcase
        if (!ok) begin
          res_next[nres_next] = mk_res(EV_FINISH, '0, '0, 1'b0, 1'b0, '0, ST_NOT_ID3, 1'b0);
          nres_next = nres_next + 2'd1;
          phase_next = PH_DONE;
        end else if (pos < 4'd9) begin
          header_position_next = pos + 4'd1;
        end else if (size_shift_next[31] || (size_shift_next > {4'd0, max_tag_size}) ||
                     (size_shift_next[31:SIZE_BITS] != '0)) begin
          res_next[nres_next] = mk_res(EV_FINISH, '0, '0, 1'b0, 1'b0, '0, ST_BAD_TAG, 1'b0);
          nres_next = nres_next + 2'd1;
          phase_next = PH_DONE;
        end else begin
          album_seen_next = 1'b0;
          res_next[nres_next] = mk_res(EV_TAG, '0, '0, 1'b0, 1'b0, '0, ST_OK, 1'b0);
          nres_next = nres_next + 2'd1;
          tag_remaining_next = size_shift_next[27:0];
          header_position_next = '0;
          phase_next = PH_FRAME_HDR;
          if (size_shift_next[27:0] == '0) begin
            res_next[nres_next] = mk_res(EV_FINISH, '0, '0, 1'b0, 1'b0, '0, ST_OK, 1'b0);
            nres_next = nres_next + 2'd1;
            phase_next = PH_DONE;
          end
        end
      end
      PH_FRAME_HDR, PH_ENC, PH_VALUE, PH_PADDING: begin
        if (tag_remaining != '0) begin
          tag_remaining_next = tag_remaining - 28'd1;
        end
        if (phase == PH_FRAME_HDR) begin
          if ((pos == 4'd0) && (b == 8'd0)) begin
            phase_next = PH_PADDING;
          end else begin
            if (pos == 4'd0) begin
              frame_id_next = {24'd0, b};
            end else if (pos < 4'd4) begin
              frame_id_next = {frame_id[23:0], b};
            end else if (pos < 4'd8) begin
              size_shift_next = size_push((pos == 4'd4) ? 32'd0 : size_shift, b,
                                          syncsafe_mode);
            end
            if (pos >= 4'd9) begin
              if (size_shift[31] || (size_shift == '0) ||
                  (size_shift > {4'd0, tag_remaining_next})) begin
                res_next[nres_next] = mk_res(EV_FINISH, '0, '0, 1'b0, 1'b0, '0,
                                             ST_BAD_FRAME, 1'b0);
                nres_next = nres_next + 2'd1;
                phase_next = PH_DONE;
              end else begin
                value_remaining_next = size_shift[27:0];
                frame_category_next = classify(frame_id);
                header_position_next = '0;
                phase_next = PH_ENC;
              end
            end else begin
              header_position_next = pos + 4'd1;
            end
          end
        end else if (phase == PH_ENC) begin
          if (value_remaining != '0) begin
            value_remaining_next = value_remaining - 28'd1;
          end
          if ((b != 8'd0) && (b != 8'd3)) begin
            frame_category_next = CAT_NONE;
          end
          number_parse_state_next = '0;
          acc_next[0] = '0;
          acc_next[1] = '0;
          if (frame_category_next == CAT_ALBUM) begin
            album_seen_next = 1'b1;
          end
          phase_next = PH_VALUE;
          if (value_remaining_next == '0) begin
            do_end = 1'b1;
            end_empty = 1'b1;
          end
        end else if (phase == PH_VALUE) begin
          if (value_remaining != '0) begin
            value_remaining_next = value_remaining - 28'd1;
          end
          if (frame_category <= CAT_LAST_TEXT) begin
            res_next[nres_next] = mk_res(EV_TEXT, frame_category, b, 1'b1,
                                         value_remaining_next == '0, '0, ST_OK, 1'b0);
            nres_next = nres_next + 2'd1;
          end else if ((frame_category == CAT_TRACK) || (frame_category == CAT_DISC)) begin
            if ((b == 8'h2F) && !slot) begin
              number_parse_state_next = 3'b100;
            end else if ((sub == 2'd0) && space) begin
              number_parse_state_next = number_parse_state;
            end else if ((sub == 2'd0) && ((b == 8'h2B) || (b == 8'h2D))) begin
              if (b == 8'h2D) begin
                acc_next[slot][32] = 1'b1;
              end
              number_parse_state_next = {slot, 2'd1};
            end else if (sub == 2'd3) begin
              number_parse_state_next = number_parse_state;
            end else if (digit) begin
              mag = ({3'd0, acc[slot][31:0]} << 3) + ({3'd0, acc[slot][31:0]} << 1) +
                    {31'd0, b[3:0]};
              if (mag > 35'h0_8000_0000) begin
                mag = 35'h0_8000_0000;
              end
              acc_next[slot] = {acc[slot][32], mag[31:0]};
              number_parse_state_next = {slot, 2'd2};
            end else begin
              number_parse_state_next = {slot, 2'd3};
            end
          end
          if (value_remaining_next == '0) begin
            do_end = 1'b1;
          end
        end

        if (do_end) begin
          if ((frame_category_next <= CAT_LAST_TEXT) && end_empty) begin
            res_next[nres_next] = mk_res(EV_TEXT, frame_category_next, '0, 1'b0, 1'b1, '0,
                                         ST_OK, 1'b0);
            nres_next = nres_next + 2'd1;
          end else if ((frame_category_next == CAT_TRACK) ||
                       (frame_category_next == CAT_DISC)) begin
            first = acc_value(acc_next[0]);
            if (first != '0) begin
              res_next[nres_next] = mk_res(EV_NUMBER, frame_category_next, '0, 1'b0, 1'b0,
                                           first, ST_OK, 1'b0);
              nres_next = nres_next + 2'd1;
              if (frame_category_next == CAT_DISC) begin
                album_seen_next = 1'b1;
              end
              if (number_parse_state_next[2]) begin
                cnt = acc_value(acc_next[1]);
                if (cnt != '0) begin
                  res_next[nres_next] = mk_res(EV_NUMBER, frame_category_next + 5'd1, '0,
                                               1'b0, 1'b0, cnt, ST_OK, 1'b0);
                  nres_next = nres_next + 2'd1;
                  album_seen_next = 1'b1;
                end
              end
            end
          end
          phase_next = PH_FRAME_HDR;
          header_position_next = '0;
        end

        if ((phase_next != PH_DONE) && (tag_remaining_next == '0)) begin
          res_next[nres_next] = mk_res(EV_FINISH, '0, '0, 1'b0, 1'b0, '0,
                                       ((phase_next == PH_FRAME_HDR) &&
                                        (header_position_next != '0)) ?
                                       ST_BAD_FRAME : ST_OK,
                                       !((phase_next == PH_FRAME_HDR) &&
                                         (header_position_next != '0)) &&
                                       album_seen_next);
          nres_next = nres_next + 2'd1;
          phase_next = PH_DONE;
        end
      end
      default: begin
        phase_next = phase;
      end
    endcase

    if (end_of_stream) begin
      if (phase_next == PH_HEADER) begin
        res_next[nres_next] = mk_res(EV_FINISH, '0, '0, 1'b0, 1'b0, '0, ST_NOT_ID3, 1'b0);
        nres_next = nres_next + 2'd1;
      end else if (phase_next != PH_DONE) begin
        res_next[nres_next] = mk_res(EV_FINISH, '0, '0, 1'b0, 1'b0, '0, ST_TRUNC, 1'b0);
        nres_next = nres_next + 2'd1;
      end
      phase_next = PH_HEADER;
      header_position_next = '0;
      syncsafe_mode_next = 1'b0;
      size_shift_next = '0;
      tag_remaining_next = '0;
      frame_id_next = '0;
      value_remaining_next = '0;
      frame_category_next = '0;
      acc_next[0] = '0;
      acc_next[1] = '0;
      number_parse_state_next = '0;
      album_seen_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_HEADER;
      header_position <= '0;
      syncsafe_mode <= 1'b0;
      size_shift <= '0;
      tag_remaining <= '0;
      frame_id <= '0;
      value_remaining <= '0;
      frame_category <= '0;
      acc[0] <= '0;
      acc[1] <= '0;
      number_parse_state <= '0;
      album_seen <= 1'b0;
    end else if (accept) begin
      phase <= phase_next;
      header_position <= header_position_next;
      syncsafe_mode <= syncsafe_mode_next;
      size_shift <= size_shift_next;
      tag_remaining <= tag_remaining_next;
      frame_id <= frame_id_next;
      value_remaining <= value_remaining_next;
      frame_category <= frame_category_next;
      acc[0] <= acc_next[0];
      acc[1] <= acc_next[1];
      number_parse_state <= number_parse_state_next;
      album_seen <= album_seen_next;
    end
  end

endmodule
`default_nettype wire

// ===== hdl/idtp_outq.sv =====
// Result buffer that holds the results of one byte and hands them out one per transaction.
`default_nettype none
module idtp_outq import idtp_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  load,
  input  wire res_t  load_res [MAX_RES],
  input  wire logic [1:0] load_n,
  output logic       can_load,
  output logic       out_valid,
  input  wire logic  out_ready,
  output res_t       out_res,
  output logic [1:0] count
);

  res_t       entries [MAX_RES];
  logic [1:0] rd;
  logic       pop;

  assign pop       = out_valid && out_ready;
  assign out_valid = (count != 2'd0);
  assign can_load  = (count == 2'd0) || ((count == 2'd1) && out_ready);
  assign out_res   = entries[rd];

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      rd <= '0;
    end else if (load) begin
      count <= load_n;
      rd <= '0;
    end else if (pop) begin
      count <= count - 2'd1;
      rd <= rd + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      for (int i = 0; i < MAX_RES; i++) begin
        entries[i] <= load_res[i];
      end
    end
  end

endmodule
`default_nettype wire

// ===== hdl/id3v2_tag_frame_parser_top.sv =====
// Output: the results of a byte are registered; the first appears in the cycle after the byte is accepted.
// Throughput: one byte per cycle while each byte yields at most one result and m_tready is high;
// a byte that yields more results holds the input while they drain.
// Reset (synchronous, active high) returns the parser to the header search,
// empties the result buffer and sets max_tag_size to 300000.
`default_nettype none
`include "id3v2_tag_frame_parser_top_defines.svh"
module id3v2_tag_frame_parser_top import idtp_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // [7:0] data_byte
  input  wire logic        s_tlast,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [55:0]      m_tdata,   // [4:0] category, [12:5] text_byte, [13] byte_valid,
                                      // [45:14] number, [48:46] status, [49] album_present
  output logic             m_tlast,
  output logic [1:0]       m_tuser,   // [1:0] event_res
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  logic [27:0] max_tag_size;
  logic        s_accept;
  res_t        step_res [MAX_RES];
  logic [1:0]  step_n;
  phase_t      phase;
  res_t        out_res;
  logic [1:0]  q_count;

  assign pready   = 1'b1;
  assign prdata   = paddr[2] ? 32'd0 : {4'd0, max_tag_size};
  assign s_accept = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_tag_size <= MAX_TAG_RESET;
    end else if (psel && penable && pwrite && pready && !paddr[2]) begin
      max_tag_size <= pwdata[27:0];
    end
  end

  idtp_step u_step (
    .clk(clk), .rst(rst), .accept(s_accept), .data_byte(s_tdata),
    .end_of_stream(s_tlast), .max_tag_size(max_tag_size),
    .res_next(step_res), .nres_next(step_n), .phase(phase)
  );

  idtp_outq u_outq (
    .clk(clk), .rst(rst), .load(s_accept), .load_res(step_res), .load_n(step_n),
    .can_load(s_tready), .out_valid(m_tvalid), .out_ready(m_tready),
    .out_res(out_res), .count(q_count)
  );

  assign m_tuser = out_res.ev;
  assign m_tlast = out_res.last;
  assign m_tdata = {6'd0, out_res.alb, out_res.st, out_res.num, out_res.bv,
                    out_res.tb, out_res.cat};

  `IDTP_ASSERT_NEXT(a_eos_resets, s_accept && s_tlast, phase == PH_HEADER, "phase not reset")
  `IDTP_ASSERT_NEXT(a_load_count, s_accept, q_count == $past(step_n), "buffer count mismatch")
  `IDTP_ASSERT_SAME(a_done_quiet, s_accept && (phase == PH_DONE), step_n == 2'd0,
                    "result after finish")

endmodule
`default_nettype wire

// ===== tb/tb_id3v2_tag_frame_parser_top.sv =====
// Self-checking testbench for the ID3v2 tag frame parser: byte streams in, predicted events out.
module tb_id3v2_tag_frame_parser_top;
  import idtp_pkg::*;

  localparam logic [2:0] REG_MAX_TAG_SIZE = 3'd0;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = '0;
  logic        s_tlast = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [55:0] m_tdata;
  logic        m_tlast;
  logic [1:0]  m_tuser;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  id3v2_tag_frame_parser_top DUT (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
    .m_tuser(m_tuser),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready)
  );

  always #2 clk = ~clk;

  // Parser state mirrored for prediction.
  phase_t      ph;
  int          hpos;
  bit          sync_size;
  logic [31:0] size_acc;
  logic [31:0] tag_left;
  logic [31:0] frame_tag;
  logic [31:0] value_left;
  logic [4:0]  frame_cat;
  logic [32:0] num_acc [2];
  logic [2:0]  num_state;
  bit          album_flag;
  logic [27:0] max_size;
  int          step_results;

  res_t        events_due[$];
  int          errors = 0;
  int          bytes_sent = 0;
  int          events_seen = 0;
  int          files_sent = 0;

  logic [7:0]  file_bytes[$];
  logic [7:0]  body_bytes[$];
  logic [7:0]  value_bytes[$];

  function automatic void clear_parser();
    ph = PH_HEADER; hpos = 0; sync_size = 0; size_acc = 0; tag_left = 0;
    frame_tag = 0; value_left = 0; frame_cat = 0; num_acc[0] = 0; num_acc[1] = 0;
    num_state = 0; album_flag = 0;
  endfunction

  function automatic void add_event(logic [1:0] ev, logic [4:0] cat, logic [7:0] tb,
                                    logic bv, logic last, logic [31:0] num,
                                    logic [2:0] st, logic alb);
    res_t r;
    if (step_results < 4) begin
      r.ev = ev; r.cat = cat; r.tb = tb; r.bv = bv; r.last = last;
      r.num = num; r.st = st; r.alb = alb;
      events_due.push_back(r);
      step_results++;
    end
  endfunction

  function automatic void close_tag(logic [2:0] st);
    add_event(EV_FINISH, 5'd0, 8'd0, 1'b0, 1'b0, 32'd0, st, (st == ST_OK) && album_flag);
    ph = PH_DONE;
  endfunction

  function automatic logic [31:0] shift_size(logic [31:0] acc, logic [7:0] b);
    if (sync_size) return {acc[31] | b[7], acc[23:0], b[6:0]};
    return {acc[23:0], b};
  endfunction

  function automatic logic [4:0] frame_class(logic [31:0] id);
    case (id)
      "TIT1": return 5'd0;
      "TIT2": return 5'd1;
      "TIT3": return 5'd2;
      "TLAN": return 5'd3;
      "TCOP": return 5'd4;
      "TDRL", "TDAT", "TYER", "TDRC": return 5'd5;
      "TPE1", "TPE2", "TPE3", "TPE4": return 5'd6;
      "TPUB", "TENC": return 5'd7;
      "TALB", "TOAL": return CAT_ALBUM;
      "TCON": return 5'd9;
      "TLEN": return 5'd10;
      "TEXT": return 5'd11;
      "TCOM": return 5'd12;
      "TRCK": return CAT_TRACK;
      "TPOS": return CAT_DISC;
      default: return CAT_NONE;
    endcase
  endfunction

  function automatic logic [31:0] signed_value(logic [32:0] a);
    if (a[32]) return 32'd0 - a[31:0];
    if (a[31:0] > 32'h7FFF_FFFF) return 32'h7FFF_FFFF;
    return a[31:0];
  endfunction

  function automatic void scan_number(logic [7:0] b);
    int slot;
    int sub;
    bit digit;
    bit space;
    logic [32:0] a;
    logic [35:0] mag;
    slot = num_state[2];
    sub = num_state[1:0];
    digit = (b >= "0") && (b <= "9");
    space = (b == " ") || (b >= 8'd9 && b <= 8'd13);
    if (b == "/" && slot == 0) begin
      num_state = 3'd4;
      return;
    end
    if (sub == 0) begin
      if (space) return;
      if (b == "+" || b == "-") begin
        if (b == "-") num_acc[slot][32] = 1'b1;
        num_state = {slot[0], 2'd1};
        return;
      end
    end
    if (sub == 3) return;
    if (digit) begin
      a = num_acc[slot];
      mag = a[31:0] * 36'd10 + (b - 8'd48);
      if (mag > 36'h8000_0000) mag = 36'h8000_0000;
      num_acc[slot] = {a[32], mag[31:0]};
      num_state = {slot[0], 2'd2};
    end else begin
      num_state = {slot[0], 2'd3};
    end
  endfunction

  function automatic void close_value(bit empty);
    logic [31:0] first;
    logic [31:0] cnt;
    if (frame_cat <= CAT_LAST_TEXT && empty) begin
      add_event(EV_TEXT, frame_cat, 8'd0, 1'b0, 1'b1, 32'd0, ST_OK, 1'b0);
    end else if (frame_cat == CAT_TRACK || frame_cat == CAT_DISC) begin
      first = signed_value(num_acc[0]);
      if (first != 0) begin
        add_event(EV_NUMBER, frame_cat, 8'd0, 1'b0, 1'b0, first, ST_OK, 1'b0);
        if (frame_cat == CAT_DISC) album_flag = 1;
        if (num_state[2]) begin
          cnt = signed_value(num_acc[1]);
          if (cnt != 0) begin
            add_event(EV_NUMBER, frame_cat + 5'd1, 8'd0, 1'b0, 1'b0, cnt, ST_OK, 1'b0);
            album_flag = 1;
          end
        end
      end
    end
    ph = PH_FRAME_HDR;
    hpos = 0;
  endfunction

  function automatic void header_step(logic [7:0] b);
    int pos;
    bit ok;
    pos = hpos;
    ok = 1;
    case (pos)
      0: ok = (b == "I");
      1: ok = (b == "D");
      2: ok = (b == "3");
      3: begin
        ok = (b <= 8'd4);
        sync_size = (b == 8'd4);
        size_acc = 0;
      end
      5: ok = (b == 8'd0);
      default: if (pos >= 6) size_acc = shift_size(size_acc, b);
    endcase
    if (!ok) begin
      close_tag(ST_NOT_ID3);
      return;
    end
    if (pos < 9) begin
      hpos = pos + 1;
      return;
    end
    if (size_acc[31] || size_acc > {4'd0, max_size} || size_acc > 32'h0FFF_FFFF) begin
      close_tag(ST_BAD_TAG);
      return;
    end
    album_flag = 0;
    add_event(EV_TAG, 5'd0, 8'd0, 1'b0, 1'b0, 32'd0, ST_OK, 1'b0);
    tag_left = size_acc;
    hpos = 0;
    ph = PH_FRAME_HDR;
    if (tag_left == 0) close_tag(ST_OK);
  endfunction

  function automatic void body_step(logic [7:0] b);
    int pos;
    if (tag_left > 0) tag_left--;
    if (ph == PH_FRAME_HDR) begin
      pos = hpos;
      if (pos == 0 && b == 0) begin
        ph = PH_PADDING;
      end else begin
        if (pos == 0) frame_tag = {24'd0, b};
        else if (pos < 4) frame_tag = {frame_tag[23:0], b};
        else if (pos < 8) begin
          if (pos == 4) size_acc = 0;
          size_acc = shift_size(size_acc, b);
        end
        if (pos >= 9) begin
          if (size_acc[31] || size_acc == 0 || size_acc > tag_left) begin
            close_tag(ST_BAD_FRAME);
            return;
          end
          value_left = size_acc;
          frame_cat = frame_class(frame_tag);
          hpos = 0;
          ph = PH_ENC;
        end else begin
          hpos = pos + 1;
        end
      end
    end else if (ph == PH_ENC) begin
      if (value_left > 0) value_left--;
      if (b != 0 && b != 3) frame_cat = CAT_NONE;
      num_state = 0;
      num_acc[0] = 0;
      num_acc[1] = 0;
      if (frame_cat == CAT_ALBUM) album_flag = 1;
      ph = PH_VALUE;
      if (value_left == 0) close_value(1);
    end else if (ph == PH_VALUE) begin
      if (value_left > 0) value_left--;
      if (frame_cat <= CAT_LAST_TEXT)
        add_event(EV_TEXT, frame_cat, b, 1'b1, value_left == 0, 32'd0, ST_OK, 1'b0);
      else if (frame_cat == CAT_TRACK || frame_cat == CAT_DISC)
        scan_number(b);
      if (value_left == 0) close_value(0);
    end
    if (ph != PH_DONE && tag_left == 0) begin
      if (ph == PH_FRAME_HDR && hpos != 0) close_tag(ST_BAD_FRAME);
      else close_tag(ST_OK);
    end
  endfunction

  function automatic void predict_byte(logic [7:0] b, logic eos);
    step_results = 0;
    if (ph == PH_HEADER) header_step(b);
    else if (ph != PH_DONE) body_step(b);
    if (eos) begin
      if (ph == PH_HEADER) close_tag(ST_NOT_ID3);
      else if (ph != PH_DONE) close_tag(ST_TRUNC);
      clear_parser();
    end
  endfunction

  always @(posedge clk) begin
    if (!rst && s_tvalid && s_tready) predict_byte(s_tdata, s_tlast);
  end

  always @(posedge clk) begin
    res_t want;
    res_t got;
    if (!rst && m_tvalid && m_tready) begin
      events_seen++;
      got.ev = m_tuser; got.cat = m_tdata[4:0]; got.tb = m_tdata[12:5];
      got.bv = m_tdata[13]; got.last = m_tlast; got.num = m_tdata[45:14];
      got.st = m_tdata[48:46]; got.alb = m_tdata[49];
      if (events_due.size() == 0) begin
        errors++;
        $display("%0t: unexpected transaction, actual %p", $time, got);
      end else begin
        want = events_due.pop_front();
        if (got.ev != want.ev)
          $display("%0t: event_res expected %0d actual %0d", $time, want.ev, got.ev);
        if (got.cat != want.cat)
          $display("%0t: category expected %0d actual %0d", $time, want.cat, got.cat);
        if (got.tb != want.tb)
          $display("%0t: text_byte expected %h actual %h", $time, want.tb, got.tb);
        if (got.bv != want.bv)
          $display("%0t: byte_valid expected %0d actual %0d", $time, want.bv, got.bv);
        if (got.last != want.last)
          $display("%0t: last_of_value expected %0d actual %0d", $time, want.last, got.last);
        if (got.num != want.num)
          $display("%0t: number expected %0d actual %0d", $time,
                   $signed(want.num), $signed(got.num));
        if (got.st != want.st)
          $display("%0t: status expected %0d actual %0d", $time, want.st, got.st);
        if (got.alb != want.alb)
          $display("%0t: album_present expected %0d actual %0d", $time, want.alb, got.alb);
        if (got != want) errors++;
      end
    end
  end

  // Result-side back-pressure: busy windows alternate with free-running ones.
  int ready_hold = 0;
  int cyc = 0;
  always @(posedge clk) begin
    cyc++;
    if (rst) begin
      m_tready <= 1'b0;
    end else if ((cyc / 300) % 3 == 2) begin
      m_tready <= 1'b1;
    end else if (ready_hold > 0) begin
      ready_hold--;
      m_tready <= 1'b0;
    end else if ($urandom_range(0, 99) < 4) begin
      ready_hold = $urandom_range(6, 25);
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(0, 99) < 75);
    end
  end

  int gaps_on = 1;

  task automatic send_byte(logic [7:0] b, logic eos);
    int g;
    int r;
    r = $urandom_range(0, 99);
    g = !gaps_on ? 0 : (r < 60) ? 0 : (r < 92) ? $urandom_range(1, 3) : $urandom_range(6, 20);
    if (g > 0) begin
      s_tvalid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= b;
    s_tlast <= eos;
    do @(posedge clk); while (!(s_tvalid && s_tready));
    bytes_sent++;
  endtask

  task automatic send_file();
    foreach (file_bytes[i]) send_byte(file_bytes[i], i == file_bytes.size() - 1);
    file_bytes.delete();
    files_sent++;
  endtask

  // The first edge lets the prediction of the last accepted byte land in the queue.
  task automatic wait_idle();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (events_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic apb_write(logic [2:0] addr, logic [31:0] value);
    wait_idle();
    psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0; paddr <= addr; pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    if (addr == REG_MAX_TAG_SIZE) max_size = value[27:0];
  endtask

  function automatic void put_size(logic [31:0] s, bit sync);
    if (sync) begin
      file_bytes.push_back({1'b0, s[27:21]}); file_bytes.push_back({1'b0, s[20:14]});
      file_bytes.push_back({1'b0, s[13:7]});  file_bytes.push_back({1'b0, s[6:0]});
    end else begin
      file_bytes.push_back(s[31:24]); file_bytes.push_back(s[23:16]);
      file_bytes.push_back(s[15:8]);  file_bytes.push_back(s[7:0]);
    end
  endfunction

  function automatic void put_header(logic [7:0] ver, logic [31:0] s);
    file_bytes.push_back("I"); file_bytes.push_back("D"); file_bytes.push_back("3");
    file_bytes.push_back(ver); file_bytes.push_back(8'($urandom_range(0, 255)));
    file_bytes.push_back(8'd0);
    put_size(s, ver == 8'd4);
  endfunction

  function automatic void set_value(string v);
    value_bytes.delete();
    for (int i = 0; i < v.len(); i++) value_bytes.push_back(v[i]);
  endfunction

  // Appends one frame to the body, value taken from value_bytes.
  function automatic void add_frame(logic [31:0] id, logic [7:0] enc, bit sync);
    logic [31:0] s;
    logic [7:0]  tmp[$];
    s = value_bytes.size() + 1;
    tmp = file_bytes;
    file_bytes.delete();
    put_size(s, sync);
    body_bytes.push_back(id[31:24]); body_bytes.push_back(id[23:16]);
    body_bytes.push_back(id[15:8]);  body_bytes.push_back(id[7:0]);
    foreach (file_bytes[i]) body_bytes.push_back(file_bytes[i]);
    body_bytes.push_back(8'd0); body_bytes.push_back(8'd0);
    body_bytes.push_back(enc);
    foreach (value_bytes[i]) body_bytes.push_back(value_bytes[i]);
    file_bytes = tmp;
  endfunction

  task automatic send_tag(logic [7:0] ver, int pad);
    put_header(ver, body_bytes.size() + pad);
    foreach (body_bytes[i]) file_bytes.push_back(body_bytes[i]);
    repeat (pad) file_bytes.push_back(8'd0);
    file_bytes.push_back(8'($urandom_range(0, 255)));
    body_bytes.delete();
    send_file();
  endtask

  task automatic test_header_checks();
    file_bytes = '{"I", "X", "3"};                 send_file();
    file_bytes = '{"I", "D"};                      send_file();
    put_header(8'd5, 32'd20);                      send_file();
    file_bytes = '{"I", "D", "3", 8'd3, 8'd0, 8'h40, 8'd0, 8'd0, 8'd0, 8'd5};
    send_file();
    put_header(8'd4, 32'd0); file_bytes[7] = 8'h81; send_file();
    put_header(8'd3, 32'h8000_0010);               send_file();
    put_header(8'd3, 32'd300001);                  send_file();
    put_header(8'd2, 32'd0);                       send_file();
    put_header(8'd3, 32'd40); file_bytes.push_back("T"); send_file();
  endtask

  task automatic test_frame_checks();
    set_value("Hi"); add_frame("TIT2", 8'd0, 1);
    body_bytes[7] = 8'd0;
    send_tag(8'd4, 0);
    set_value("Hello"); add_frame("TALB", 8'd0, 0);
    body_bytes[7] = 8'd60;
    send_tag(8'd3, 0);
    set_value("ab"); add_frame("TCOM", 8'd3, 0);
    body_bytes.push_back("T"); body_bytes.push_back("P");
    send_tag(8'd3, 0);
    set_value("x"); add_frame("TPE1", 8'd3, 1);
    send_tag(8'd4, 3);
    set_value("skip"); add_frame("TIT1", 8'd1, 0);
    set_value("");     add_frame("TLAN", 8'd0, 0);
    set_value("q");    add_frame("ZZZZ", 8'd0, 0);
    send_tag(8'd3, 0);
  endtask

  task automatic test_numbers();
    set_value(" \t+12/ 3");          add_frame("TRCK", 8'd0, 0);
    set_value("99999999999/-99999999999"); add_frame("TPOS", 8'd3, 0);
    set_value("-7/0");               add_frame("TRCK", 8'd0, 0);
    set_value("0/9");                add_frame("TPOS", 8'd0, 0);
    set_value("4x/5");               add_frame("TPOS", 8'd0, 0);
    set_value("2147483648");         add_frame("TRCK", 8'd3, 0);
    set_value("-2147483649/");       add_frame("TRCK", 8'd0, 0);
    send_tag(8'd3, 0);
    set_value("5/");                 add_frame("TPOS", 8'd0, 1);
    set_value("3");                  add_frame("TPOS", 8'd0, 1);
    send_tag(8'd4, 0);
  endtask

  task automatic test_size_register();
    apb_write(REG_MAX_TAG_SIZE, 32'd0);
    put_header(8'd3, 32'd1);                     send_file();
    put_header(8'd3, 32'd0);                     send_file();
    apb_write(REG_MAX_TAG_SIZE, 32'h0FFF_FFFF);
    put_header(8'd3, 32'h0FFF_FFFF); file_bytes.push_back("T"); send_file();
    put_header(8'd3, 32'h1000_0000);             send_file();
    put_header(8'd4, 32'h0FFF_FFFF);             send_file();
    apb_write(REG_MAX_TAG_SIZE, 32'd50);
    set_value("abc"); add_frame("TOAL", 8'd0, 0); send_tag(8'd3, 0);
    put_header(8'd3, 32'd51);                    send_file();
    apb_write(REG_MAX_TAG_SIZE, 32'd300000);
  endtask

  function automatic logic [31:0] pick_id();
    logic [31:0] ids[19] = '{"TIT1", "TIT2", "TIT3", "TLAN", "TCOP", "TDRL", "TYER",
                             "TPE1", "TPE4", "TENC", "TALB", "TOAL", "TCON", "TLEN",
                             "TEXT", "TCOM", "TRCK", "TPOS", "WXYZ"};
    int k;
    k = $urandom_range(0, 21);
    if (k >= 19) k = 16 + (k % 2);
    return ids[k];
  endfunction

  function automatic void random_value(logic [31:0] id);
    int n;
    logic [7:0] alphabet[16] = '{"0", "1", "5", "9", "/", "/", "+", "-", " ", 8'd9,
                                 "7", "3", "x", 8'd0, 8'hFF, 8'd13};
    value_bytes.delete();
    n = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 7);
    repeat (n) begin
      if ((id == "TRCK" || id == "TPOS") && $urandom_range(0, 9) != 0)
        value_bytes.push_back(alphabet[$urandom_range(0, 15)]);
      else
        value_bytes.push_back(8'($urandom_range(0, 255)));
    end
  endfunction

  // Random files until the whole run reaches at least 380 bytes, and always at least three of them.
  task automatic test_random_files();
    int kind;
    int nfr;
    int pad;
    bit v4;
    logic [31:0] id;
    logic [7:0]  enc;
    int first_file;
    first_file = files_sent;
    while (bytes_sent < 380 || files_sent < first_file + 3) begin
      gaps_on = ($urandom_range(0, 4) != 0);
      if (files_sent % 7 == 3) wait_idle();
      v4 = $urandom_range(0, 1);
      nfr = $urandom_range(1, 4);
      repeat (nfr) begin
        id = pick_id();
        enc = ($urandom_range(0, 5) == 0) ? 8'($urandom_range(0, 255)) :
                                            8'($urandom_range(0, 1) * 3);
        random_value(id);
        add_frame(id, enc, v4);
      end
      pad = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 4) : 0;
      kind = $urandom_range(0, 9);
      if (kind < 7) begin
        send_tag(v4 ? 8'd4 : 8'd3, pad);
      end else begin
        put_header(v4 ? 8'd4 : 8'($urandom_range(0, 3)), body_bytes.size() + pad);
        foreach (body_bytes[i]) file_bytes.push_back(body_bytes[i]);
        body_bytes.delete();
        if (kind == 7) file_bytes = file_bytes[0:$urandom_range(0, file_bytes.size() - 2)];
        else file_bytes[$urandom_range(0, file_bytes.size() - 1)] = 8'($urandom_range(0, 255));
        send_file();
      end
    end
  endtask

  initial begin
    clear_parser();
    max_size = MAX_TAG_RESET;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_header_checks();
    test_frame_checks();
    test_numbers();
    test_size_register();
    test_random_files();
    wait_idle();
    $display("Sent %0d bytes in %0d files and checked %0d result transactions,", bytes_sent,
             files_sent, events_seen);
    $display("covering header errors, frame walks, numbers, padding and size limits.");
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Timeout with %0d results outstanding.", events_due.size());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
